### sv/fmp_pkg.sv
// ----------------------------------------------------------------------------
// fmp_pkg: shared types and constants for the Fibonacci modulo-prime block
// Holds the prime, the Barrett reciprocal, the controller-to-datapath command
// and status structures, and the modular add used in several places.
// ----------------------------------------------------------------------------
package fmp_pkg;

    localparam int ELEM_W  = 30;
    localparam int INDEX_W = 64;

    typedef logic [ELEM_W-1:0] elem_t;

    // The modulus, and floor(2^60 / prime) for Barrett reduction.
    localparam elem_t       FIB_PRIME = 30'd1000000009;
    localparam logic [63:0] MU_FULL   = (64'd1 << 60) / 64'd1000000009;
    localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

    // Bits of the index magnitude that are walked, most significant first.
    localparam int MAG_W = INDEX_W - 1;

    typedef enum logic [1:0] {
        MUL_AA,
        MUL_BB,
        MUL_DD,
        MUL_BS
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     shift;
        logic     calc_s;
        logic     issue;
        mul_sel_t mul_sel;
        logic     upd_sq;
        logic     upd_base;
        logic     final_res;
    } cmd_t;

    typedef struct packed {
        logic top_bit;
        logic neg;
    } status_t;

    // Sum of two residues, reduced once back below the prime.
    function automatic elem_t mod_add(input elem_t x, input elem_t y);
        logic [ELEM_W:0] sum;
        logic [ELEM_W:0] diff;
        sum  = {1'b0, x} + {1'b0, y};
        diff = sum - {1'b0, FIB_PRIME};
        if (sum >= {1'b0, FIB_PRIME})
            return diff[ELEM_W-1:0];
        else
            return sum[ELEM_W-1:0];
    endfunction

endpackage

### sv/fmp_modmul.sv
// ----------------------------------------------------------------------------
// fmp_modmul: pipelined modular multiplier
// Four stages: product, Barrett quotient estimate, quotient times prime, and
// final subtraction with up to two corrections. One product per cycle.
// ----------------------------------------------------------------------------
module fmp_modmul (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    input  fmp_pkg::mul_sel_t op_tag,
    input  fmp_pkg::elem_t    op_x,
    input  fmp_pkg::elem_t    op_y,
    output logic              res_valid,
    output fmp_pkg::mul_sel_t res_tag,
    output fmp_pkg::elem_t    res_value
);
    import fmp_pkg::*;

    logic [2*ELEM_W-1:0] t_reg;
    logic [2*ELEM_W-1:0] t_next;
    logic [61:0]         q_reg;
    logic [61:0]         q_next;
    logic [31:0]         tlo2_reg;
    logic [31:0]         tlo3_reg;
    logic [31:0]         qp_reg;
    logic [60:0]         qp_full;
    logic [31:0]         r_diff;
    logic [31:0]         r_less1;
    logic [31:0]         r_less2;
    logic [31:0]         prime32;
    logic [31:0]         prime32x2;
    elem_t               res_next;
    elem_t               res_reg;
    logic [3:0]          valid_reg;
    mul_sel_t            tag1_reg;
    mul_sel_t            tag2_reg;
    mul_sel_t            tag3_reg;
    mul_sel_t            tag4_reg;

    assign prime32   = {2'b00, FIB_PRIME};
    assign prime32x2 = {1'b0, FIB_PRIME, 1'b0};

    assign t_next  = op_x * op_y;
    assign q_next  = t_reg[2*ELEM_W-1:ELEM_W-1] * BARRETT_MU;
    assign qp_full = q_reg[61:31] * FIB_PRIME;

    // The estimate is at most two below the true quotient, so the remainder
    // lies below three times the prime and fits in 32 bits.
    always_comb
    begin
        r_diff  = tlo3_reg - qp_reg;
        r_less1 = r_diff - prime32;
        r_less2 = r_diff - prime32x2;
        priority if (r_diff >= prime32x2)
            res_next = r_less2[ELEM_W-1:0];
        else if (r_diff >= prime32)
            res_next = r_less1[ELEM_W-1:0];
        else
            res_next = r_diff[ELEM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[2:0], op_valid};
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        tag1_reg <= op_tag;
        q_reg    <= q_next;
        tlo2_reg <= t_reg[31:0];
        tag2_reg <= tag1_reg;
        qp_reg   <= qp_full[31:0];
        tlo3_reg <= tlo2_reg;
        tag3_reg <= tag2_reg;
        res_reg  <= res_next;
        tag4_reg <= tag3_reg;
    end

    assign res_valid = valid_reg[3];
    assign res_tag   = tag4_reg;
    assign res_value = res_reg;

endmodule

### sv/fmp_datapath.sv
// ----------------------------------------------------------------------------
// fmp_datapath: matrix registers and result for the Fibonacci block
// Holds the symmetric power matrix [[a,b],[b,d]], the index shifter, the
// captured products and the result register, all driven by controller commands.
// ----------------------------------------------------------------------------
module fmp_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fmp_pkg::cmd_t                cmd,
    input  logic [fmp_pkg::INDEX_W-1:0]  index,
    output fmp_pkg::status_t             status,
    output fmp_pkg::elem_t               fib_value
);
    import fmp_pkg::*;

    elem_t            a_reg;
    elem_t            b_reg;
    elem_t            d_reg;
    elem_t            s_reg;
    elem_t            paa_reg;
    elem_t            pbb_reg;
    elem_t            pdd_reg;
    elem_t            pbs_reg;
    elem_t            res_reg;
    logic [MAG_W-1:0] n_reg;
    logic             neg_reg;
    logic             ones_reg;
    elem_t            mul_x;
    elem_t            mul_y;
    logic             mul_valid;
    mul_sel_t         mul_tag;
    elem_t            mul_res;

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_AA:
            begin
                mul_x = a_reg;
                mul_y = a_reg;
            end
            MUL_BB:
            begin
                mul_x = b_reg;
                mul_y = b_reg;
            end
            MUL_DD:
            begin
                mul_x = d_reg;
                mul_y = d_reg;
            end
            MUL_BS:
            begin
                mul_x = b_reg;
                mul_y = s_reg;
            end
            default:
            begin
                mul_x = a_reg;
                mul_y = a_reg;
            end
        endcase
    end

    fmp_modmul u_modmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (cmd.issue),
        .op_tag    (cmd.mul_sel),
        .op_x      (mul_x),
        .op_y      (mul_y),
        .res_valid (mul_valid),
        .res_tag   (mul_tag),
        .res_value (mul_res)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg    <= elem_t'(1);
            b_reg    <= '0;
            d_reg    <= elem_t'(1);
            n_reg    <= index[MAG_W-1:0];
            neg_reg  <= index[INDEX_W-1];
            ones_reg <= &index;
        end
        else
        begin
            if (cmd.shift)
                n_reg <= {n_reg[MAG_W-2:0], 1'b0};
            if (cmd.upd_sq)
            begin
                a_reg <= mod_add(paa_reg, pbb_reg);
                b_reg <= pbs_reg;
                d_reg <= mod_add(pbb_reg, pdd_reg);
            end
            else if (cmd.upd_base)
            begin
                a_reg <= mod_add(a_reg, b_reg);
                b_reg <= a_reg;
                d_reg <= b_reg;
            end
        end

        if (cmd.calc_s)
            s_reg <= mod_add(a_reg, d_reg);

        if (mul_valid)
        begin
            unique case (mul_tag)
                MUL_AA:  paa_reg <= mul_res;
                MUL_BB:  pbb_reg <= mul_res;
                MUL_DD:  pdd_reg <= mul_res;
                MUL_BS:  pbs_reg <= mul_res;
                default: pbs_reg <= mul_res;
            endcase
        end

        if (cmd.final_res)
        begin
            if (neg_reg)
                res_reg <= ones_reg ? elem_t'(1) : elem_t'(0);
            else
                res_reg <= mod_add(a_reg, b_reg);
        end
    end

    assign status.top_bit = n_reg[MAG_W-1];
    assign status.neg     = neg_reg;
    assign fib_value      = res_reg;

endmodule

### sv/fmp_ctrl.sv
// ----------------------------------------------------------------------------
// fmp_ctrl: sequencer for the Fibonacci block
// Walks the index bits, runs the squaring schedule on the shared multiplier
// and owns both handshakes.
// ----------------------------------------------------------------------------
module fmp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    input  fmp_pkg::status_t status,
    output fmp_pkg::cmd_t    cmd
);
    import fmp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ROUND,
        ST_FINAL
    } state_t;

    // Round schedule: four issues, pipeline wait, square update, base step.
    localparam logic [3:0] PH_AA   = 4'd0;
    localparam logic [3:0] PH_BB   = 4'd1;
    localparam logic [3:0] PH_DD   = 4'd2;
    localparam logic [3:0] PH_BS   = 4'd3;
    localparam logic [3:0] PH_SQ   = 4'd8;
    localparam logic [3:0] PH_BASE = 4'd9;

    localparam logic [5:0] LAST_BIT = 6'(MAG_W - 1);

    state_t     state_reg;
    logic [3:0] phase_reg;
    logic [5:0] cnt_reg;
    logic       rsp_valid_reg;
    logic       slot_free;

    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
                cmd.load = req_valid;
            ST_SCAN:
            begin
                cmd.shift    = !status.neg;
                cmd.upd_base = !status.neg && status.top_bit;
            end
            ST_ROUND:
            begin
                unique case (phase_reg)
                    PH_AA:
                    begin
                        cmd.calc_s  = 1'b1;
                        cmd.issue   = 1'b1;
                        cmd.mul_sel = MUL_AA;
                    end
                    PH_BB:
                    begin
                        cmd.issue   = 1'b1;
                        cmd.mul_sel = MUL_BB;
                    end
                    PH_DD:
                    begin
                        cmd.issue   = 1'b1;
                        cmd.mul_sel = MUL_DD;
                    end
                    PH_BS:
                    begin
                        cmd.issue   = 1'b1;
                        cmd.mul_sel = MUL_BS;
                    end
                    PH_SQ:
                    begin
                        cmd.upd_sq = 1'b1;
                        cmd.shift  = !status.top_bit;
                    end
                    PH_BASE:
                    begin
                        cmd.upd_base = 1'b1;
                        cmd.shift    = 1'b1;
                    end
                    default:
                        cmd.issue = 1'b0;
                endcase
            end
            ST_FINAL:
                cmd.final_res = slot_free;
            default:
                cmd.load = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // A new result takes the output register in the same edge that
            // the previous one leaves it.
            priority if (state_reg == ST_FINAL && slot_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= ST_SCAN;
                        cnt_reg   <= LAST_BIT;
                    end
                end
                ST_SCAN:
                begin
                    priority if (status.neg || cnt_reg == '0)
                        state_reg <= ST_FINAL;
                    else
                    begin
                        cnt_reg <= cnt_reg - 6'd1;
                        if (status.top_bit)
                        begin
                            state_reg <= ST_ROUND;
                            phase_reg <= PH_AA;
                        end
                    end
                end
                ST_ROUND:
                begin
                    priority if ((phase_reg == PH_SQ && !status.top_bit)
                                 || phase_reg == PH_BASE)
                    begin
                        if (cnt_reg == '0)
                            state_reg <= ST_FINAL;
                        else
                        begin
                            cnt_reg   <= cnt_reg - 6'd1;
                            phase_reg <= PH_AA;
                        end
                    end
                    else
                        phase_reg <= phase_reg + 4'd1;
                end
                ST_FINAL:
                begin
                    if (slot_free)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### sv/fibonacci_mod_prime.sv
// ----------------------------------------------------------------------------
// fibonacci_mod_prime: Fibonacci numbers modulo the prime 1000000009
// Answers F(n+2) mod 1000000009 for a signed 64-bit index n >= 0 by raising
// the matrix [[1,1],[1,0]] to the power n with square-and-multiply.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload                   Direction
//   request   req_valid/req_stall   index (64 bits, signed)   into block
//   response  rsp_valid/rsp_stall   fib_value (30 bits)       out of block
//
// One item is worked on at a time; req_stall is high from the accepting edge
// until the result has been written to the output register.
// Timing is set by the round schedule on the shared four-stage modular
// multiplier and grows with the position of the leading one of the index
// and with the number of ones below it. Negative indices skip the rounds
// and give 1 for n = -1 and 0 for every other negative n.
// The output register decouples the sides: a new item is accepted while a
// result still waits; the next result is held back only if that one is unread.
// Reset (rst_n, asynchronous) clears the sequencer and the output valid flag.
//
module fibonacci_mod_prime (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic signed [fmp_pkg::INDEX_W-1:0]  index,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [fmp_pkg::ELEM_W-1:0]          fib_value
);
    import fmp_pkg::*;

    cmd_t    cmd;
    status_t status;

    // The controller decides the schedule; the datapath only executes the
    // commands and reports the current index bit and the sign.
    fmp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // The matrix is always symmetric, so only a, b and d are kept, and a
    // squaring needs four products: a*a, b*b, d*d and b*(a+d).
    fmp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .index     (index),
        .status    (status),
        .fib_value (fib_value)
    );

    // An accepted item always keeps the request side busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request side not busy after an accepted item");

    // A delivered value is always a fully reduced residue.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> fib_value < FIB_PRIME)
        else $error("result not reduced below the prime");

    // The result register is never written over a result still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.final_res |-> !(rsp_valid && rsp_stall))
        else $error("waiting result overwritten");

    // The square update comes only after the last product, b*s, has left the pipeline and been captured.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd_sq |-> $past(cmd.issue, 5) && $past(cmd.mul_sel, 5) == MUL_BS)
        else $error("square update out of step with the multiplier");

endmodule
